[rtl/fic_pkg.sv]
package fic_pkg;

  localparam int SIZE_BITS = 24;
  localparam int LIMIT_W   = 25;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [31:0]        CRC_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0]        CRC_POLY    = 32'hEDB8_8320;
  localparam logic [7:0]         BYTE_MASK   = 8'hFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;

  typedef enum logic [1:0] {
    ST_PASS  = 2'd0,
    ST_MAGIC = 2'd1,
    ST_SIZE  = 2'd2,
    ST_CRC   = 2'd3
  } status_t;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_MAGIC     = 2'd0,
    REG_APP_LIMIT = 2'd1,
    REG_DL_LIMIT  = 2'd2,
    REG_CHECK_CRC = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        op;
    logic [31:0] header_magic;
    logic [31:0] image_size;
    logic [31:0] expected_crc;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] computed_crc;
    logic        clear_request;
  } result_t;

  typedef struct packed {
    logic [31:0]        expected_magic;
    logic [LIMIT_W-1:0] app_region_limit;
    logic [LIMIT_W-1:0] download_region_limit;
    logic               check_crc;
  } cfg_t;

endpackage

[rtl/fic_cfg.sv]
module fic_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fic_pkg::ADDR_W-1:0]  paddr,
  input  logic [fic_pkg::DATA_W-1:0]  pwdata,
  output logic [fic_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output fic_pkg::cfg_t               cfg
);

  fic_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = fic_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_magic        <= '0;
      cfg.app_region_limit      <= fic_pkg::LIMIT_RESET;
      cfg.download_region_limit <= fic_pkg::LIMIT_RESET;
      cfg.check_crc             <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        fic_pkg::REG_MAGIC:     cfg.expected_magic        <= pwdata;
        fic_pkg::REG_APP_LIMIT: cfg.app_region_limit      <= pwdata[fic_pkg::LIMIT_W-1:0];
        fic_pkg::REG_DL_LIMIT:  cfg.download_region_limit <= pwdata[fic_pkg::LIMIT_W-1:0];
        fic_pkg::REG_CHECK_CRC: cfg.check_crc             <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      fic_pkg::REG_MAGIC:     prdata = cfg.expected_magic;
      fic_pkg::REG_APP_LIMIT: prdata = {{(fic_pkg::DATA_W-fic_pkg::LIMIT_W){1'b0}},
                                        cfg.app_region_limit};
      fic_pkg::REG_DL_LIMIT:  prdata = {{(fic_pkg::DATA_W-fic_pkg::LIMIT_W){1'b0}},
                                        cfg.download_region_limit};
      fic_pkg::REG_CHECK_CRC: prdata = {{(fic_pkg::DATA_W-1){1'b0}}, cfg.check_crc};
      default: ;
    endcase
  end

endmodule

[rtl/fic_engine.sv]
module fic_engine #(
  parameter int SIZE_BITS = fic_pkg::SIZE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  fic_pkg::cfg_t    cfg,
  input  logic             item_valid,
  output logic             item_stall,
  input  fic_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output fic_pkg::result_t result
);

  localparam logic [32:0] SIZE_CAP = 33'd1 << SIZE_BITS;

  function automatic logic [31:0] fold_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b & fic_pkg::BYTE_MASK};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? fic_pkg::CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // Input register
  logic             s1_valid;
  fic_pkg::item_t   s1;

  // Check state
  logic                        armed;
  logic                        armed_next;
  logic [31:0]                 crc;
  logic [31:0]                 crc_next;
  logic [fic_pkg::LIMIT_W-1:0] remaining;
  logic [fic_pkg::LIMIT_W-1:0] remaining_next;
  logic [31:0]                 held_crc;
  logic [31:0]                 held_crc_next;

  logic                        out_load;
  logic                        fire;
  logic                        has_result;
  fic_pkg::result_t            result_next;
  logic [32:0]                 cap;
  logic [32:0]                 size_ext;
  logic                        size_bad;
  logic [31:0]                 crc_fold;
  logic [31:0]                 final_crc;
  logic [fic_pkg::LIMIT_W-1:0] remaining_dec;

  assign out_load   = !result_valid || !result_stall;
  assign item_stall = s1_valid && !out_load;
  assign fire       = s1_valid && out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1 <= item;
    end
  end

  always_comb begin
    cap = SIZE_CAP;
    if ({8'd0, cfg.app_region_limit} < cap) begin
      cap = {8'd0, cfg.app_region_limit};
    end
    if ({8'd0, cfg.download_region_limit} < cap) begin
      cap = {8'd0, cfg.download_region_limit};
    end
  end

  assign size_ext      = {1'b0, s1.image_size};
  assign size_bad      = (s1.image_size == 32'd0) || (size_ext > cap);
  assign crc_fold      = fold_byte(crc, s1.data_byte);
  assign final_crc     = crc_fold ^ fic_pkg::CRC_ONES;
  assign remaining_dec = remaining - {{(fic_pkg::LIMIT_W-1){1'b0}}, 1'b1};

  always_comb begin
    armed_next     = armed;
    crc_next       = crc;
    remaining_next = remaining;
    held_crc_next  = held_crc;
    has_result     = 1'b0;
    result_next    = '0;
    if (fire) begin
      if (s1.op == fic_pkg::OP_HEADER) begin
        armed_next     = 1'b0;
        crc_next       = fic_pkg::CRC_ONES;
        remaining_next = '0;
        if (s1.header_magic != cfg.expected_magic) begin
          has_result         = 1'b1;
          result_next.status = fic_pkg::ST_MAGIC;
        end else if (size_bad) begin
          has_result         = 1'b1;
          result_next.status = fic_pkg::ST_SIZE;
        end else if (!cfg.check_crc) begin
          has_result         = 1'b1;
          result_next.status = fic_pkg::ST_PASS;
        end else begin
          armed_next     = 1'b1;
          remaining_next = s1.image_size[fic_pkg::LIMIT_W-1:0];
          held_crc_next  = s1.expected_crc;
        end
      end else if (armed) begin
        remaining_next = remaining_dec;
        if (remaining_dec != '0) begin
          crc_next = crc_fold;
        end else begin
          armed_next               = 1'b0;
          crc_next                 = fic_pkg::CRC_ONES;
          has_result               = 1'b1;
          result_next.computed_crc = final_crc;
          if (final_crc == held_crc) begin
            result_next.status = fic_pkg::ST_PASS;
          end else begin
            result_next.status        = fic_pkg::ST_CRC;
            result_next.clear_request = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      crc       <= fic_pkg::CRC_ONES;
      remaining <= '0;
      held_crc  <= '0;
    end else begin
      armed     <= armed_next;
      crc       <= crc_next;
      remaining <= remaining_next;
      held_crc  <= held_crc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && has_result) begin
      result <= result_next;
    end
  end

endmodule

[rtl/firmware_image_crc_checker_top.sv]
// Firmware image CRC checker. A header item checks the magic word and the image size against
// the smaller region limit and 2**SIZE_BITS, and returns magic_mismatch, size_invalid or, with
// CRC checking off, pass at once; otherwise it arms the block, and each following data item
// folds one byte into a reflected CRC-32 until the header size is reached, when pass or
// crc_mismatch (with clear_request) is returned. One item is accepted per clock cycle unless
// the input is stalled; the byte-wide CRC update sits between the input register and the
// result register. A stalled result holds back the input only while the input register also
// holds an item. Data items while not armed give no result. Configuration is to be written
// through the APB-style port while the block is idle; the block itself does not enforce this.
module firmware_image_crc_checker_top #(
  parameter int SIZE_BITS = fic_pkg::SIZE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fic_pkg::ADDR_W-1:0]  paddr,
  input  logic [fic_pkg::DATA_W-1:0]  pwdata,
  output logic [fic_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  fic_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output fic_pkg::result_t            result
);

  fic_pkg::cfg_t cfg;

  fic_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fic_engine #(
    .SIZE_BITS (SIZE_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[rtl/fic_checker.sv]
module fic_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input fic_pkg::result_t            result
);

  // A stalled result is held unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Input back-pressure only arises from a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

  // clear_request goes with a CRC mismatch and nothing else.
  a_clear_req: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.clear_request == (result.status == fic_pkg::ST_CRC)))
    else $error("clear_request does not match status");

  // Header rejections carry no computed CRC.
  a_no_crc: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == fic_pkg::ST_MAGIC || result.status == fic_pkg::ST_SIZE)
    |-> result.computed_crc == 32'd0)
    else $error("rejected header reports a CRC");

endmodule

bind firmware_image_crc_checker_top fic_checker u_fic_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import fic_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_WAIT  = 6;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    item_t     it;
    bit        typed;
    status_t   typed_status;
    reg_idx_t  idx;
    logic [31:0] value;
  } row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                item_valid;
  logic                item_stall;
  item_t               item;
  logic                result_valid;
  logic                result_stall;
  result_t             result;

  cfg_t                cfg_model;
  logic [31:0]         model_crc;
  logic [LIMIT_W-1:0]  model_left;
  logic [31:0]         model_held;
  logic                model_armed;

  result_t             expected_verdicts[$];
  row_t                directed_rows[$];
  int                  errors = 0;
  int                  counted = 0;
  int                  burst_left = 0;
  bit                  no_gaps = 0;

  firmware_image_crc_checker_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    crc = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
    end
    return crc;
  endfunction

  function automatic logic [32:0] size_cap();
    logic [32:0] cap;
    cap = 33'd1 << SIZE_BITS;
    if ({8'd0, cfg_model.app_region_limit} < cap) begin
      cap = {8'd0, cfg_model.app_region_limit};
    end
    if ({8'd0, cfg_model.download_region_limit} < cap) begin
      cap = {8'd0, cfg_model.download_region_limit};
    end
    return cap;
  endfunction

  function automatic bit predict_verdict(input item_t it, output result_t res);
    logic [32:0] cap;
    logic [31:0] fin;
    res = '0;
    if (it.op == OP_HEADER) begin
      cap = size_cap();
      model_armed = 1'b0;
      model_crc = CRC_ONES;
      model_left = '0;
      if (it.header_magic != cfg_model.expected_magic) begin
        res.status = ST_MAGIC;
        return 1'b1;
      end
      if (it.image_size == 32'd0 || {1'b0, it.image_size} > cap) begin
        res.status = ST_SIZE;
        return 1'b1;
      end
      if (!cfg_model.check_crc) begin
        res.status = ST_PASS;
        return 1'b1;
      end
      model_armed = 1'b1;
      model_left = it.image_size[LIMIT_W-1:0];
      model_held = it.expected_crc;
      return 1'b0;
    end
    if (!model_armed) begin
      return 1'b0;
    end
    model_crc = crc_fold(model_crc, it.data_byte);
    model_left = model_left - {{(LIMIT_W-1){1'b0}}, 1'b1};
    if (model_left != '0) begin
      return 1'b0;
    end
    fin = model_crc ^ CRC_ONES;
    model_armed = 1'b0;
    model_crc = CRC_ONES;
    res.computed_crc = fin;
    if (fin == model_held) begin
      res.status = ST_PASS;
    end else begin
      res.status = ST_CRC;
      res.clear_request = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic item_t hdr_item(input logic [31:0] magic, input logic [31:0] size,
                                     input logic [31:0] crc);
    item_t it;
    it.op = OP_HEADER;
    it.header_magic = magic;
    it.image_size = size;
    it.expected_crc = crc;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic item_t data_item(input logic [7:0] b);
    item_t it;
    it.op = OP_DATA;
    it.header_magic = $urandom;
    it.image_size = $urandom;
    it.expected_crc = $urandom;
    it.data_byte = b;
    return it;
  endfunction

  function automatic row_t item_row(input item_t it, input bit typed, input status_t st);
    row_t r;
    r.kind = ROW_ITEM;
    r.it = it;
    r.typed = typed;
    r.typed_status = st;
    r.idx = REG_MAGIC;
    r.value = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(input reg_idx_t idx, input logic [31:0] value);
    row_t r;
    r.kind = ROW_CFG;
    r.it = '0;
    r.typed = 1'b0;
    r.typed_status = ST_PASS;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic logic [31:0] pick_size(input logic [32:0] cap);
    logic [32:0] s;
    case ($urandom_range(0, 19))
      0:       s = {1'b0, $urandom_range(100, 300)};
      1, 2, 3: s = {1'b0, $urandom_range(9, 40)};
      4:       s = (cap <= 33'd300 && cap != 0) ? cap : 33'd1;
      default: s = {1'b0, $urandom_range(1, 8)};
    endcase
    if (s > cap) begin
      s = cap;
    end
    if (s == 0) begin
      s = 33'd1;
    end
    return s[31:0];
  endfunction

  // Sets the item up at this edge and returns at the edge where it is taken.
  task automatic send_item(input item_t it, input bit typed, input status_t st);
    result_t res;
    result_t typed_res;
    bit      has_res;
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    has_res = predict_verdict(it, res);
    if (typed) begin
      typed_res = '0;
      typed_res.status = st;
      expected_verdicts.push_back(typed_res);
    end else if (has_res) begin
      expected_verdicts.push_back(res);
    end
    counted++;
  endtask

  task automatic sender_pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAGIC:     cfg_model.expected_magic = val;
      REG_APP_LIMIT: cfg_model.app_region_limit = val[LIMIT_W-1:0];
      REG_DL_LIMIT:  cfg_model.download_region_limit = val[LIMIT_W-1:0];
      REG_CHECK_CRC: cfg_model.check_crc = val[0];
      default:       ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_limit();
    case ($urandom_range(0, 19))
      0:             return 32'd0;
      1, 2:          return 32'h01FF_FFFF;
      3, 4, 5, 6:    return 32'h0100_0000;
      7, 8:          return $urandom & 32'h01FF_FFFF;
      default:       return $urandom_range(8, 300);
    endcase
  endfunction

  task automatic configure_random();
    logic [31:0] magic;
    case ($urandom_range(0, 3))
      0:       magic = 32'd0;
      1:       magic = 32'hFFFF_FFFF;
      default: magic = $urandom;
    endcase
    apb_write(REG_MAGIC, magic);
    apb_write(REG_APP_LIMIT, random_limit());
    apb_write(REG_DL_LIMIT, random_limit());
    apb_write(REG_CHECK_CRC, {31'd0, ($urandom_range(0, 3) != 0)});
  endtask

  task automatic run_phase(input int target);
    int          choice;
    int          n;
    logic [32:0] cap;
    logic [31:0] size;
    logic [31:0] want;
    logic [31:0] magic;
    logic [31:0] crc;
    logic [7:0]  bytes[$];
    while (counted < target) begin
      cap = size_cap();
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        size = pick_size(cap);
        bytes.delete();
        crc = CRC_ONES;
        for (int k = 0; k < size; k++) begin
          bytes.push_back(8'($urandom));
          crc = crc_fold(crc, bytes[k]);
        end
        crc = crc ^ CRC_ONES;
        case ($urandom_range(0, 3))
          0:       want = $urandom;
          1:       want = crc ^ (32'd1 << $urandom_range(0, 31));
          default: want = crc;
        endcase
        n = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, size - 1)) : int'(size);
        send_item(hdr_item(cfg_model.expected_magic, size, want), 1'b0, ST_PASS);
        sender_pace();
        for (int k = 0; k < n; k++) begin
          send_item(data_item(bytes[k]), 1'b0, ST_PASS);
          sender_pace();
        end
      end else if (choice < 80) begin
        magic = $urandom;
        if (magic == cfg_model.expected_magic) begin
          magic = ~magic;
        end
        send_item(hdr_item(magic, pick_size(cap), $urandom), 1'b0, ST_PASS);
        sender_pace();
      end else if (choice < 90) begin
        case ($urandom_range(0, 2))
          0:       size = 32'd0;
          1:       size = cap[31:0] + 32'd1;
          default: size = $urandom;
        endcase
        send_item(hdr_item(cfg_model.expected_magic, size, $urandom), 1'b0, ST_PASS);
        sender_pace();
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_item(data_item(8'($urandom)), 1'b0, ST_PASS);
          sender_pace();
        end
      end
    end
  endtask

  initial begin
    int stall_left;
    int stall_mode;
    int run_left;
    bit run_level;
    result_stall <= 1'b0;
    stall_left = 0;
    stall_mode = 0;
    run_left = 0;
    run_level = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(40, 200);
      end
      stall_left--;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_level = ~run_level;
            run_left = $urandom_range(1, 10);
          end
          run_left--;
          result_stall <= run_level;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d crc %h clear %b",
                 $time, result.status, result.computed_crc, result.clear_request);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, result.status);
          errors++;
        end
        if (result.computed_crc !== want.computed_crc) begin
          $display("%0t: computed_crc expected %h got %h",
                   $time, want.computed_crc, result.computed_crc);
          errors++;
        end
        if (result.clear_request !== want.clear_request) begin
          $display("%0t: clear_request expected %b got %b",
                   $time, want.clear_request, result.clear_request);
          errors++;
        end
      end
    end
  end

  initial begin
    int phase_target;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_valid <= 1'b0;
    item <= '0;
    cfg_model.expected_magic = 32'd0;
    cfg_model.app_region_limit = LIMIT_RESET;
    cfg_model.download_region_limit = LIMIT_RESET;
    cfg_model.check_crc = 1'b1;
    model_crc = CRC_ONES;
    model_left = '0;
    model_held = '0;
    model_armed = 1'b0;

    directed_rows.push_back(item_row(hdr_item(32'hFFFF_FFFF, 32'd1, 32'd0), 1'b1, ST_MAGIC));
    directed_rows.push_back(item_row(data_item(8'hFF), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'd0, 32'd0), 1'b1, ST_SIZE));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'hFFFF_FFFF, 32'd0), 1'b1, ST_SIZE));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'h0100_0001, 32'd0), 1'b1, ST_SIZE));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'd1, 32'hD202_EF8D), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'h00), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'd1, 32'd0), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'hFF), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'h0100_0000, 32'hFFFF_FFFF),
                                     1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'h3C), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'd2, 32'h1234_5678), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'hA5), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'h5A), 1'b0, ST_PASS));
    directed_rows.push_back(cfg_row(REG_MAGIC, 32'hDEAD_BEEF));
    directed_rows.push_back(item_row(hdr_item(32'd0, 32'd1, 32'd0), 1'b1, ST_MAGIC));
    directed_rows.push_back(cfg_row(REG_APP_LIMIT, 32'h01FF_FFFF));
    directed_rows.push_back(item_row(hdr_item(32'hDEAD_BEEF, 32'h0100_0001, 32'd0),
                                     1'b1, ST_SIZE));
    directed_rows.push_back(cfg_row(REG_DL_LIMIT, 32'd0));
    directed_rows.push_back(item_row(hdr_item(32'hDEAD_BEEF, 32'd1, 32'd0), 1'b1, ST_SIZE));
    directed_rows.push_back(cfg_row(REG_DL_LIMIT, 32'd4));
    directed_rows.push_back(item_row(hdr_item(32'hDEAD_BEEF, 32'd5, 32'd0), 1'b1, ST_SIZE));
    directed_rows.push_back(cfg_row(REG_CHECK_CRC, 32'd0));
    directed_rows.push_back(item_row(hdr_item(32'hDEAD_BEEF, 32'd4, 32'd0), 1'b1, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'h12), 1'b0, ST_PASS));
    directed_rows.push_back(cfg_row(REG_CHECK_CRC, 32'd1));
    directed_rows.push_back(item_row(hdr_item(32'hDEAD_BEEF, 32'd4, $urandom), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'h00), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'hFF), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'h80), 1'b0, ST_PASS));
    directed_rows.push_back(item_row(data_item(8'h01), 1'b0, ST_PASS));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        apb_write(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].typed_status);
        sender_pace();
      end
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      settle();
      configure_random();
      no_gaps = ($urandom_range(0, 3) == 0);
      phase_target = counted + PHASE_ITEMS;
      if (phase_target > RANDOM_ITEMS) begin
        phase_target = RANDOM_ITEMS;
      end
      run_phase(phase_target);
    end

    settle();
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
